[rtl/ilp_pkg.sv]
// Shared types, codes and helpers for the integer literal parser.
// Used by ilp_if.sv, ilp_step.sv and integer_literal_parser_unit.sv.
package ilp_pkg;

   localparam int VALUE_BITS = 16;
   localparam int TOKEN_BITS = 16;

   localparam logic [3:0] MODE_IDLE       = 4'd0;
   localparam logic [3:0] MODE_START      = 4'd1;
   localparam logic [3:0] MODE_ZERO       = 4'd2;
   localparam logic [3:0] MODE_HEX        = 4'd3;
   localparam logic [3:0] MODE_OCT        = 4'd4;
   localparam logic [3:0] MODE_PLUS       = 4'd5;
   localparam logic [3:0] MODE_MINUS      = 4'd6;
   localparam logic [3:0] MODE_MINUS_SKIP = 4'd7;
   localparam logic [3:0] MODE_DEC        = 4'd8;
   localparam logic [3:0] MODE_CHAR       = 4'd9;
   localparam logic [3:0] MODE_ESC        = 4'd10;
   localparam logic [3:0] MODE_ESC_OCT    = 4'd11;

   localparam logic [1:0] KIND_HEX = 2'd0;
   localparam logic [1:0] KIND_OCT = 2'd1;
   localparam logic [1:0] KIND_DEC = 2'd2;
   localparam logic [1:0] KIND_CHR = 2'd3;

   localparam logic [1:0] ESC_DIGITS_MAX = 2'd3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_LOWER_X = 8'h78;

   localparam logic [7:0] BYTE_FF = 8'h0C;
   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_BS = 8'h08;
   localparam logic [7:0] BYTE_HT = 8'h09;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic [3:0] mode;
      value_type  acc;
      logic       neg;
      logic [1:0] esc_cnt;
      logic [9:0] esc_val;
   } state_type;

   typedef struct packed {
      logic                  emit;
      logic [TOKEN_BITS-1:0] value;
      logic [1:0]            kind;
      logic                  recognized;
      logic                  taken;
   } result_type;

   function automatic value_type push_byte(value_type acc, logic [7:0] b);
      return (acc << 8) | VALUE_BITS'(b);
   endfunction

   function automatic logic [TOKEN_BITS-1:0] to_token(value_type v);
      return TOKEN_BITS'(v);
   endfunction

endpackage

[rtl/ilp_if.sv]
// Valid/ready channel interfaces for the integer literal parser.
// Depends on ilp_pkg.
interface ilp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_char;
   logic       begin_token;

   modport source (output valid, output src_char, output begin_token, input ready);
   modport sink (input valid, input src_char, input begin_token, output ready);
endinterface

interface ilp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ilp_pkg::TOKEN_BITS-1:0] token_value;
   logic [1:0]                    token_kind;
   logic                          recognized;
   logic                          byte_taken;

   modport source (output valid, output token_value, output token_kind,
                   output recognized, output byte_taken, input ready);
   modport sink (input valid, input token_value, input token_kind,
                 input recognized, input byte_taken, output ready);
endinterface

[rtl/ilp_step.sv]
// Next-state and result logic for one source byte of the literal parser.
// Depends on ilp_pkg.
module ilp_step (
   input  ilp_pkg::state_type  state,
   input  logic [7:0]          src_char,
   input  logic                begin_token,
   output ilp_pkg::state_type  nxt,
   output ilp_pkg::result_type res
);
   import ilp_pkg::*;

   state_type  cur;
   logic       is_blank;
   logic       is_digit;
   logic       is_hex_letter;
   logic [3:0] digit;
   logic       do_body;
   value_type  body_acc;
   value_type  pushed;
   logic [9:0] esc_next;
   logic [1:0] cnt_next;

   always_comb begin
      cur = state;
      if (begin_token) begin
         cur      = '0;
         cur.mode = MODE_START;
      end
      is_blank      = (src_char == CH_SPACE) || (src_char == CH_NUL);
      is_digit      = src_char inside {[CH_ZERO:CH_NINE]};
      is_hex_letter = src_char inside {[CH_UPPER_A:CH_UPPER_F], [CH_LOWER_A:CH_LOWER_F]};
      digit         = src_char[3:0];
      esc_next      = {cur.esc_val[6:0], 3'b000} + 10'(digit);
      cnt_next      = cur.esc_cnt + 2'd1;
      pushed        = push_byte(cur.acc, cur.esc_val[7:0]);
      do_body       = 1'b0;
      body_acc      = cur.acc;
      nxt           = cur;
      res           = '0;

      case (cur.mode)
         MODE_START, MODE_PLUS: begin
            if (is_blank) begin
            end else if (src_char == CH_ZERO && cur.mode == MODE_START) begin
               nxt.mode = MODE_ZERO;
            end else if (src_char == CH_PLUS && cur.mode == MODE_START) begin
               nxt.mode = MODE_PLUS;
            end else if (src_char == CH_MINUS) begin
               nxt.neg  = 1'b1;
               nxt.mode = MODE_MINUS;
            end else if (is_digit) begin
               nxt.acc  = VALUE_BITS'(digit);
               nxt.mode = MODE_DEC;
            end else if (src_char == CH_QUOTE) begin
               nxt.acc  = '0;
               nxt.mode = MODE_CHAR;
            end else begin
               res.emit = 1'b1;
            end
         end
         MODE_ZERO: begin
            if (src_char == CH_LOWER_X || src_char == CH_UPPER_X) begin
               nxt.acc  = '0;
               nxt.mode = MODE_HEX;
            end else if (is_digit) begin
               nxt.acc  = VALUE_BITS'(digit);
               nxt.mode = MODE_OCT;
            end else begin
               res.emit       = 1'b1;
               res.kind       = KIND_OCT;
               res.recognized = 1'b1;
            end
         end
         MODE_HEX: begin
            if (is_digit) begin
               nxt.acc = (cur.acc << 4) + VALUE_BITS'(digit);
            end else if (is_hex_letter) begin
               nxt.acc = (cur.acc << 4) + VALUE_BITS'(digit + 4'd9);
            end else begin
               res.emit       = 1'b1;
               res.value      = to_token(cur.acc);
               res.kind       = KIND_HEX;
               res.recognized = 1'b1;
            end
         end
         MODE_OCT: begin
            if (is_digit) begin
               nxt.acc = (cur.acc << 3) + VALUE_BITS'(digit);
            end else begin
               res.emit       = 1'b1;
               res.value      = to_token(cur.acc);
               res.kind       = KIND_OCT;
               res.recognized = 1'b1;
            end
         end
         MODE_MINUS: begin
            if (is_digit) begin
               nxt.acc  = VALUE_BITS'(digit);
               nxt.mode = MODE_DEC;
            end else if (src_char == CH_QUOTE) begin
               nxt.acc  = '0;
               nxt.mode = MODE_CHAR;
            end else if (is_blank) begin
               nxt.mode = MODE_MINUS_SKIP;
            end else begin
               res.emit = 1'b1;
            end
         end
         MODE_MINUS_SKIP: begin
            if (is_blank) begin
            end else if (src_char == CH_QUOTE) begin
               nxt.acc  = '0;
               nxt.mode = MODE_CHAR;
            end else begin
               res.emit = 1'b1;
            end
         end
         MODE_DEC: begin
            if (is_digit) begin
               nxt.acc = (cur.acc << 3) + (cur.acc << 1) + VALUE_BITS'(digit);
            end else begin
               res.emit       = 1'b1;
               res.value      = to_token(cur.neg ? (VALUE_BITS'(0) - cur.acc) : cur.acc);
               res.kind       = KIND_DEC;
               res.recognized = 1'b1;
            end
         end
         MODE_CHAR: begin
            do_body = 1'b1;
         end
         MODE_ESC: begin
            nxt.mode = MODE_CHAR;
            case (src_char)
               CH_LOWER_F: nxt.acc = push_byte(cur.acc, BYTE_FF);
               CH_LOWER_R: nxt.acc = push_byte(cur.acc, BYTE_CR);
               CH_LOWER_B: nxt.acc = push_byte(cur.acc, BYTE_BS);
               CH_LOWER_T: nxt.acc = push_byte(cur.acc, BYTE_HT);
               CH_LOWER_N: nxt.acc = push_byte(cur.acc, BYTE_LF);
               default: begin
                  if (is_digit) begin
                     nxt.esc_val = 10'(digit);
                     nxt.esc_cnt = 2'd1;
                     nxt.mode    = MODE_ESC_OCT;
                  end else begin
                     nxt.acc = push_byte(cur.acc, src_char);
                     if (src_char == CH_NUL) begin
                        res.emit       = 1'b1;
                        res.value      = to_token(nxt.acc);
                        res.kind       = KIND_CHR;
                        res.recognized = 1'b1;
                     end
                  end
               end
            endcase
         end
         MODE_ESC_OCT: begin
            if (is_digit) begin
               if (cnt_next == ESC_DIGITS_MAX) begin
                  nxt.acc     = push_byte(cur.acc, esc_next[7:0]);
                  nxt.esc_cnt = '0;
                  nxt.esc_val = '0;
                  nxt.mode    = MODE_CHAR;
               end else begin
                  nxt.esc_val = esc_next;
                  nxt.esc_cnt = cnt_next;
               end
            end else begin
               nxt.esc_cnt = '0;
               nxt.esc_val = '0;
               nxt.mode    = MODE_CHAR;
               nxt.acc     = pushed;
               body_acc    = pushed;
               do_body     = 1'b1;
            end
         end
         default: begin
            nxt.mode = MODE_IDLE;
         end
      endcase

      if (do_body) begin
         if (src_char == CH_QUOTE || src_char == CH_NUL) begin
            res.emit       = 1'b1;
            res.value      = to_token(body_acc);
            res.kind       = KIND_CHR;
            res.recognized = 1'b1;
            res.taken      = (src_char == CH_QUOTE);
         end else if (src_char == CH_BSLASH) begin
            nxt.mode = MODE_ESC;
         end else begin
            nxt.acc = push_byte(body_acc, src_char);
         end
      end

      if (res.emit) begin
         nxt.mode = MODE_IDLE;
      end
   end

endmodule

[rtl/integer_literal_parser_unit.sv]
// Streaming parser for C-style integer and character constants, one byte a word.
// Depends on ilp_pkg, ilp_if and ilp_step.
// Takes one byte every cycle req is ready: the parse state and the result register
// update at the same edge, so a byte's result (if any) appears on rsp the cycle after
// it is taken, and req is ready whenever the result register is empty or being drained.
module integer_literal_parser_unit (
   input logic       clock,
   input logic       reset,
   ilp_req_if.sink   req,
   ilp_rsp_if.source rsp
);
   import ilp_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type step_res;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;
   logic       accept;

   ilp_step u_step (
      .state       (state_ff),
      .src_char    (req.src_char),
      .begin_token (req.begin_token),
      .nxt         (state_in),
      .res         (step_res)
   );

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept && step_res.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_res.emit) begin
         rsp_data_ff <= step_res;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.token_value = rsp_data_ff.value;
   assign rsp.token_kind  = rsp_data_ff.kind;
   assign rsp.recognized  = rsp_data_ff.recognized;
   assign rsp.byte_taken  = rsp_data_ff.taken;

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      accept && step_res.emit |=> state_ff.mode == MODE_IDLE && rsp_valid_ff)
      else $error("parser not idle after a result");

   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.recognized |->
         rsp_data_ff.value == '0 && rsp_data_ff.kind == KIND_HEX && !rsp_data_ff.taken)
      else $error("failure result carries a value");

   a_taken_is_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.taken |->
         rsp_data_ff.kind == KIND_CHR && rsp_data_ff.recognized)
      else $error("byte taken on a non-character result");

   a_esc_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.esc_cnt != ESC_DIGITS_MAX)
      else $error("octal escape count overrun");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !accept)
      else $error("byte taken while result is stalled");

endmodule

[sim/tb_integer_literal_parser_unit.sv]
// Testbench for integer_literal_parser_unit: directed and random source text, with a
// scoreboard class that predicts each token and checks it against the rsp channel.
// Depends on ilp_pkg, ilp_if and the RTL of the unit; needs nothing else.
`timescale 1ns / 100ps

module tb_integer_literal_parser_unit;
   import ilp_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_BYTES   = 640;
   localparam int REPORT_LIMIT   = 20;

   typedef struct packed {
      logic [TOKEN_BITS-1:0] value;
      logic [1:0]            kind;
      logic                  recognized;
      logic                  taken;
   } token_type;

   class token_scoreboard;
      token_type  pending_tokens[$];
      int         errors;
      int         bytes_seen;
      int         tokens_checked;
      int         kind_counts[4];
      int         rejected;
      logic [3:0] mode;
      value_type  acc;
      logic       neg;
      logic [1:0] esc_cnt;
      logic [9:0] esc_val;

      function new();
         mode    = MODE_IDLE;
         acc     = '0;
         neg     = 1'b0;
         esc_cnt = '0;
         esc_val = '0;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function void shift_in(logic [7:0] b);
         acc = (acc << 8) | value_type'(b);
      endfunction

      function bit close_token(value_type v, logic [1:0] kind, logic rec, logic taken,
                               output token_type tok);
         tok.value      = TOKEN_BITS'(v);
         tok.kind       = kind;
         tok.recognized = rec;
         tok.taken      = taken;
         mode           = MODE_IDLE;
         return 1'b1;
      endfunction

      function bit quoted_byte(logic [7:0] c, output token_type tok);
         tok = '0;
         if (c == CH_QUOTE) return close_token(acc, KIND_CHR, 1'b1, 1'b1, tok);
         if (c == CH_NUL) return close_token(acc, KIND_CHR, 1'b1, 1'b0, tok);
         if (c == CH_BSLASH) begin
            mode = MODE_ESC;
            return 1'b0;
         end
         shift_in(c);
         return 1'b0;
      endfunction

      function bit parse_byte(logic [7:0] c, logic bt, output token_type tok);
         logic [7:0] dv;
         logic       blank;
         value_type  dec_val;
         tok   = '0;
         dv    = c - CH_ZERO;
         blank = (c == CH_SPACE) || (c == CH_NUL);
         if (bt) begin
            mode    = MODE_START;
            acc     = '0;
            neg     = 1'b0;
            esc_cnt = '0;
            esc_val = '0;
         end
         case (mode)
            MODE_START: begin
               if (blank) return 1'b0;
               if (c == CH_ZERO) begin
                  mode = MODE_ZERO;
                  return 1'b0;
               end
               if (c == CH_PLUS) begin
                  mode = MODE_PLUS;
                  return 1'b0;
               end
               if (c == CH_MINUS) begin
                  neg  = 1'b1;
                  mode = MODE_MINUS;
                  return 1'b0;
               end
               if (is_digit(c)) begin
                  acc  = value_type'(dv);
                  mode = MODE_DEC;
                  return 1'b0;
               end
               if (c == CH_QUOTE) begin
                  acc  = '0;
                  mode = MODE_CHAR;
                  return 1'b0;
               end
               return close_token('0, KIND_HEX, 1'b0, 1'b0, tok);
            end
            MODE_ZERO: begin
               if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                  acc  = '0;
                  mode = MODE_HEX;
                  return 1'b0;
               end
               if (is_digit(c)) begin
                  acc  = value_type'(dv);
                  mode = MODE_OCT;
                  return 1'b0;
               end
               return close_token('0, KIND_OCT, 1'b1, 1'b0, tok);
            end
            MODE_HEX: begin
               if (is_digit(c))
                  acc = value_type'(acc * 16 + dv);
               else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
                  acc = value_type'(acc * 16 + (c - CH_UPPER_A + 8'd10));
               else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
                  acc = value_type'(acc * 16 + (c - CH_LOWER_A + 8'd10));
               else
                  return close_token(acc, KIND_HEX, 1'b1, 1'b0, tok);
               return 1'b0;
            end
            MODE_OCT: begin
               if (is_digit(c)) begin
                  acc = value_type'(acc * 8 + dv);
                  return 1'b0;
               end
               return close_token(acc, KIND_OCT, 1'b1, 1'b0, tok);
            end
            MODE_PLUS: begin
               if (blank) return 1'b0;
               if (c == CH_MINUS) begin
                  neg  = 1'b1;
                  mode = MODE_MINUS;
                  return 1'b0;
               end
               if (is_digit(c)) begin
                  acc  = value_type'(dv);
                  mode = MODE_DEC;
                  return 1'b0;
               end
               if (c == CH_QUOTE) begin
                  acc  = '0;
                  mode = MODE_CHAR;
                  return 1'b0;
               end
               return close_token('0, KIND_HEX, 1'b0, 1'b0, tok);
            end
            MODE_MINUS: begin
               if (is_digit(c)) begin
                  acc  = value_type'(dv);
                  mode = MODE_DEC;
                  return 1'b0;
               end
               if (c == CH_QUOTE) begin
                  acc  = '0;
                  mode = MODE_CHAR;
                  return 1'b0;
               end
               if (blank) begin
                  mode = MODE_MINUS_SKIP;
                  return 1'b0;
               end
               return close_token('0, KIND_HEX, 1'b0, 1'b0, tok);
            end
            MODE_MINUS_SKIP: begin
               if (blank) return 1'b0;
               if (c == CH_QUOTE) begin
                  acc  = '0;
                  mode = MODE_CHAR;
                  return 1'b0;
               end
               return close_token('0, KIND_HEX, 1'b0, 1'b0, tok);
            end
            MODE_DEC: begin
               if (is_digit(c)) begin
                  acc = value_type'(acc * 10 + dv);
                  return 1'b0;
               end
               dec_val = neg ? value_type'('0 - acc) : acc;
               return close_token(dec_val, KIND_DEC, 1'b1, 1'b0, tok);
            end
            MODE_CHAR: return quoted_byte(c, tok);
            MODE_ESC: begin
               mode = MODE_CHAR;
               case (c)
                  CH_LOWER_F: shift_in(BYTE_FF);
                  CH_LOWER_R: shift_in(BYTE_CR);
                  CH_LOWER_B: shift_in(BYTE_BS);
                  CH_LOWER_T: shift_in(BYTE_HT);
                  CH_LOWER_N: shift_in(BYTE_LF);
                  default: begin
                     if (is_digit(c)) begin
                        esc_val = 10'(dv);
                        esc_cnt = 2'd1;
                        mode    = MODE_ESC_OCT;
                     end else begin
                        shift_in(c);
                        if (c == CH_NUL) return close_token(acc, KIND_CHR, 1'b1, 1'b0, tok);
                     end
                  end
               endcase
               return 1'b0;
            end
            MODE_ESC_OCT: begin
               if (is_digit(c)) begin
                  esc_val = 10'(esc_val * 8 + dv);
                  esc_cnt = esc_cnt + 2'd1;
                  if (esc_cnt >= ESC_DIGITS_MAX) begin
                     shift_in(esc_val[7:0]);
                     esc_cnt = '0;
                     esc_val = '0;
                     mode    = MODE_CHAR;
                  end
                  return 1'b0;
               end
               shift_in(esc_val[7:0]);
               esc_cnt = '0;
               esc_val = '0;
               mode    = MODE_CHAR;
               return quoted_byte(c, tok);
            end
            default: begin
               mode = MODE_IDLE;
               return 1'b0;
            end
         endcase
      endfunction

      function void note_byte(logic [7:0] c, logic bt);
         token_type tok;
         bytes_seen++;
         if (parse_byte(c, bt, tok)) pending_tokens.push_back(tok);
      endfunction

      function void report(string field, longint want, longint got);
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      endfunction

      function void check_token(token_type got);
         token_type want;
         if (pending_tokens.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: unexpected token, value 0x%h kind %0d recognized %b taken %b",
                        $time, got.value, got.kind, got.recognized, got.taken);
            return;
         end
         want = pending_tokens.pop_front();
         tokens_checked++;
         if (want.recognized) kind_counts[want.kind]++;
         else rejected++;
         if (got.value !== want.value) report("token_value", want.value, got.value);
         if (got.kind !== want.kind) report("token_kind", want.kind, got.kind);
         if (got.recognized !== want.recognized)
            report("recognized", want.recognized, got.recognized);
         if (got.taken !== want.taken) report("byte_taken", want.taken, got.taken);
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_cycles;
   int   req_calm;
   int   rsp_calm;
   int   sent_bytes;

   token_scoreboard sb = new();

   ilp_req_if req_if();
   ilp_rsp_if rsp_if();

   integer_literal_parser_unit uut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // mostly short gaps, a few long ones, and now and then a calm stretch with none
   function automatic int pick_gap(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(input logic [7:0] c, input logic bt);
      int gap;
      gap = pick_gap(req_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.src_char    <= c;
      req_if.begin_token <= bt;
      sent_bytes++;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_text(input string s, input logic first_bt);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], (i == 0) ? first_bt : 1'b0);
   endtask

   function automatic logic [7:0] any_blank();
      return $urandom_range(0, 1) ? CH_SPACE : CH_NUL;
   endfunction

   function automatic logic [7:0] dec_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] hex_digit();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return CH_ZERO + 8'(r);
      if (r < 16) return CH_UPPER_A + 8'(r - 10);
      return CH_LOWER_A + 8'(r - 16);
   endfunction

   function automatic logic [7:0] ender();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return CH_SPACE;
      if (r < 65) return CH_NUL;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int digit_count(int lo);
      return ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(lo, 4);
   endfunction

   // build one token with random content, mostly well-formed; some are cut short
   function automatic void compose_token(ref logic [7:0] q[$]);
      logic [7:0] simple_esc[5] = '{CH_LOWER_F, CH_LOWER_R, CH_LOWER_B, CH_LOWER_T, CH_LOWER_N};
      logic [7:0] c;
      bit         cut;
      int         form;
      int         signs;
      int         r;
      cut  = ($urandom_range(0, 9) == 0);
      form = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) q.push_back(any_blank());
      case (form)
         0, 1: begin
            q.push_back(CH_ZERO);
            q.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            repeat (digit_count(0)) q.push_back(hex_digit());
            if (!cut) q.push_back(ender());
         end
         2: begin
            q.push_back(CH_ZERO);
            repeat (digit_count(0)) q.push_back(dec_digit());
            if (!cut) q.push_back(ender());
         end
         3, 4: begin
            if ($urandom_range(0, 2) == 0) begin
               q.push_back(CH_PLUS);
               if ($urandom_range(0, 1)) q.push_back(any_blank());
            end
            if ($urandom_range(0, 1)) q.push_back(CH_MINUS);
            repeat (digit_count(1)) q.push_back(dec_digit());
            if (!cut) q.push_back(ender());
         end
         5, 6, 7: begin
            signs = $urandom_range(0, 5);
            if (signs == 1 || signs == 3) q.push_back(CH_PLUS);
            if (signs == 2 || signs == 3) q.push_back(CH_MINUS);
            if (signs >= 1 && signs <= 3 && $urandom_range(0, 1))
               repeat ($urandom_range(1, 2)) q.push_back(any_blank());
            q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 3)) begin
               r = $urandom_range(0, 9);
               if (r < 5) begin
                  c = 8'($urandom_range(1, 255));
                  q.push_back((c == CH_QUOTE || c == CH_BSLASH) ? CH_SPACE : c);
               end else if (r < 7) begin
                  q.push_back(CH_BSLASH);
                  q.push_back(simple_esc[$urandom_range(0, 4)]);
               end else if (r < 9) begin
                  q.push_back(CH_BSLASH);
                  repeat ($urandom_range(1, 3)) q.push_back(dec_digit());
               end else begin
                  q.push_back(CH_BSLASH);
                  q.push_back(8'($urandom_range(1, 255)));
               end
            end
            if (!cut) begin
               r = $urandom_range(0, 9);
               if (r < 7) q.push_back(CH_QUOTE);
               else if (r < 8) q.push_back(CH_NUL);
               else begin
                  q.push_back(CH_BSLASH);
                  q.push_back(CH_NUL);
               end
            end
         end
         default: begin
            r = $urandom_range(0, 2);
            if (r == 1) q.push_back(CH_PLUS);
            if (r == 2) q.push_back(CH_MINUS);
            q.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.src_char    = CH_NUL;
      req_if.begin_token = 1'b0;
      rsp_if.ready       = 1'b0;
      idle_cycles        = 0;
      req_calm           = 0;
      rsp_calm           = 0;
      sent_bytes         = 0;
   end

   initial begin : rsp_stall
      int stall;
      @(negedge reset);
      forever begin
         stall = pick_gap(rsp_calm);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   always @(posedge clock) begin : monitor
      token_type seen;
      bit        moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_if.valid && rsp_if.ready) begin
            seen.value      = rsp_if.token_value;
            seen.kind       = rsp_if.token_kind;
            seen.recognized = rsp_if.recognized;
            seen.taken      = rsp_if.byte_taken;
            sb.check_token(seen);
            moved = 1'b1;
         end
         if (req_if.valid && req_if.ready) begin
            sb.note_byte(req_if.src_char, req_if.begin_token);
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : source_text
      string      directed[] = '{" 0xFfA9 ", "0X7g", "0x;", "0 ", "0789,", "+ -65535;",
                                 "-1 ", "99999 ", "'ab'", "'\\f\\r\\b\\t\\n'",
                                 "'\\101\\7779'", "'\\4x'", "'\\q\\\\'", "'\\''",
                                 "+-  'z'", "- 5", "x", "+x", "-x", "123", "0x1 "};
      logic [7:0] word_bytes[$];
      int         random_start;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_text(directed[i], 1'b1);
      send_byte(CH_NINE, 1'b0);
      send_text("'hi", 1'b1);
      send_byte(CH_NUL, 1'b0);
      send_text("'k\\", 1'b1);
      send_byte(CH_NUL, 1'b0);
      send_byte(CH_NUL, 1'b1);
      send_text("7 ", 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text("'", 1'b1);
      send_byte(8'hFF, 1'b0);
      send_text("'", 1'b0);

      random_start = sent_bytes;
      while (sent_bytes - random_start < RANDOM_BYTES) begin
         if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end else begin
            word_bytes.delete();
            compose_token(word_bytes);
            foreach (word_bytes[i]) send_byte(word_bytes[i], i == 0);
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d source bytes; checked %0d tokens: %0d hex, %0d octal, %0d decimal,",
               sb.bytes_seen, sb.tokens_checked, sb.kind_counts[KIND_HEX],
               sb.kind_counts[KIND_OCT], sb.kind_counts[KIND_DEC]);
      $display("%0d character constants and %0d rejected, with %0d mismatches.",
               sb.kind_counts[KIND_CHR], sb.rejected, sb.errors);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
